// ----- rtl/core/sspf_pkg.sv -----
package sspf_pkg;

  // Matrix limits and derived storage sizes
  localparam int MAX_WIDTH   = 64;
  localparam int MAX_HEIGHT  = 64;
  localparam int FRAME_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W      = $clog2(FRAME_DEPTH);

  // Field widths
  localparam int DIM_W     = 7;
  localparam int POS_W     = 14;
  localparam int FRAC_W    = 8;
  localparam int INT_W     = POS_W - FRAC_W;
  localparam int CH_W      = 8;
  localparam int PIX_W     = 3 * CH_W;
  localparam int CFG_IDX_W = 2;
  localparam int OP_W      = 2;
  localparam int NB_W      = 2;

  localparam logic [DIM_W-1:0] DIM_RESET     = 7'd16;
  localparam logic [DIM_W-1:0] DIM_MIN       = 7'd2;
  localparam logic [DIM_W-1:0] DIM_MAX_W     = DIM_W'(MAX_WIDTH);
  localparam logic [DIM_W-1:0] DIM_MAX_H     = DIM_W'(MAX_HEIGHT);
  localparam logic [CH_W-1:0]  BORDER_WEIGHT = 8'd85;
  localparam logic [NB_W-1:0]  NB_LAST       = 2'd3;

  // Opcodes
  localparam logic [OP_W-1:0] OP_SPLAT = 2'd0;
  localparam logic [OP_W-1:0] OP_READ  = 2'd1;
  localparam logic [OP_W-1:0] OP_WRITE = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_NB_RD,
    ST_NB_WR,
    ST_PX_RD,
    ST_PX_WR,
    ST_RESULT
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic            clear;
    logic            load;
    logic            decode;
    logic            nb_rd;
    logic            nb_wr;
    logic            px_rd;
    logic            px_wr;
    logic            result;
    logic [NB_W-1:0] nb_idx;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic            clr_last;
    logic            ok;
    logic            nb_ok;
    logic [OP_W-1:0] op;
  } stat_t;

endpackage

// ----- rtl/core/subpixel_splat_framebuffer_top.sv -----
// Sequence per item: decode, then for a splat a read of each neighbour and, for one inside
// the matrix, a write; for read/write a single pixel step; a rejected item goes straight
// to the result. One item at a time: the next item can be taken once the result of the
// last one is registered; the single framebuffer port sets this limit.
// Reset (rst_n low, synchronous) sets both dimensions to 16, then a clearing pass
// zeroes all 4096 pixels, one a cycle, with in_ready low throughout.
module subpixel_splat_framebuffer_top (
  input  logic                             clk,
  input  logic                             rst_n,
  // item input
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [sspf_pkg::OP_W-1:0]        in_opcode,
  input  logic [sspf_pkg::POS_W-1:0]       in_x_pos,
  input  logic [sspf_pkg::POS_W-1:0]       in_y_pos,
  input  logic [sspf_pkg::CH_W-1:0]        in_red,
  input  logic [sspf_pkg::CH_W-1:0]        in_green,
  input  logic [sspf_pkg::CH_W-1:0]        in_blue,
  // result output
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             out_accepted,
  output logic [sspf_pkg::CH_W-1:0]        out_red,
  output logic [sspf_pkg::CH_W-1:0]        out_green,
  output logic [sspf_pkg::CH_W-1:0]        out_blue,
  // configuration writes
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [sspf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sspf_pkg::DIM_W-1:0]       cfg_data
);
  import sspf_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // Registers are always writable; the user must write them only while idle (not enforced here).
  assign cfg_ready = 1'b1;

  // Controller: sequences decode, per-neighbour read/modify/write, single-pixel read or write, result hand-off
  sspf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Datapath: config regs, Wu weights, address calc, framebuffer, result regs
  sspf_datapath u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .stat         (stat),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_idx      (cfg_index),
    .cfg_wdata    (cfg_data),
    .in_opcode    (in_opcode),
    .in_x_pos     (in_x_pos),
    .in_y_pos     (in_y_pos),
    .in_red       (in_red),
    .in_green     (in_green),
    .in_blue      (in_blue),
    .res_accepted (out_accepted),
    .res_red      (out_red),
    .res_green    (out_green),
    .res_blue     (out_blue)
  );

endmodule

// ----- rtl/core/sspf_ctrl.sv -----
module sspf_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  sspf_pkg::stat_t stat,
  output sspf_pkg::cmd_t  cmd
);
  import sspf_pkg::*;

  state_t          state_r, state_nxt;
  logic [NB_W-1:0] nb_idx_r, nb_idx_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      nb_idx_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      nb_idx_r    <= nb_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt  = state_r;
    nb_idx_nxt = nb_idx_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (stat.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_DECODE;
      end
      ST_DECODE: begin
        nb_idx_nxt = '0;
        if (!stat.ok) begin
          state_nxt = ST_RESULT;
        end else begin
          unique case (stat.op)
            OP_SPLAT: state_nxt = ST_NB_RD;
            OP_READ:  state_nxt = ST_PX_RD;
            OP_WRITE: state_nxt = ST_PX_WR;
            default:  state_nxt = ST_RESULT;
          endcase
        end
      end
      ST_NB_RD: begin
        if (stat.nb_ok) begin
          state_nxt = ST_NB_WR;
        end else if (nb_idx_r == NB_LAST) begin
          state_nxt = ST_RESULT;
        end else begin
          nb_idx_nxt = nb_idx_r + 1'b1;
        end
      end
      ST_NB_WR: begin
        if (nb_idx_r == NB_LAST) begin
          state_nxt = ST_RESULT;
        end else begin
          nb_idx_nxt = nb_idx_r + 1'b1;
          state_nxt  = ST_NB_RD;
        end
      end
      ST_PX_RD: state_nxt = ST_RESULT;
      ST_PX_WR: state_nxt = ST_RESULT;
      ST_RESULT: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  // Outputs
  always_comb begin
    cmd           = '0;
    cmd.nb_idx    = nb_idx_r;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      ST_CLEAR:  cmd.clear  = 1'b1;
      ST_IDLE:   cmd.load   = in_valid;
      ST_DECODE: cmd.decode = 1'b1;
      ST_NB_RD:  cmd.nb_rd  = 1'b1;
      ST_NB_WR:  cmd.nb_wr  = 1'b1;
      ST_PX_RD:  cmd.px_rd  = 1'b1;
      ST_PX_WR:  cmd.px_wr  = 1'b1;
      ST_RESULT: begin
        if (out_free) begin
          cmd.result    = 1'b1;
          out_valid_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule

// ----- rtl/core/sspf_datapath.sv -----
module sspf_datapath (
  input  logic                             clk,
  input  logic                             rst_n,
  input  sspf_pkg::cmd_t                   cmd,
  output sspf_pkg::stat_t                  stat,
  input  logic                             cfg_we,
  input  logic [sspf_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [sspf_pkg::DIM_W-1:0]       cfg_wdata,
  input  logic [sspf_pkg::OP_W-1:0]        in_opcode,
  input  logic [sspf_pkg::POS_W-1:0]       in_x_pos,
  input  logic [sspf_pkg::POS_W-1:0]       in_y_pos,
  input  logic [sspf_pkg::CH_W-1:0]        in_red,
  input  logic [sspf_pkg::CH_W-1:0]        in_green,
  input  logic [sspf_pkg::CH_W-1:0]        in_blue,
  output logic                             res_accepted,
  output logic [sspf_pkg::CH_W-1:0]        res_red,
  output logic [sspf_pkg::CH_W-1:0]        res_green,
  output logic [sspf_pkg::CH_W-1:0]        res_blue
);
  import sspf_pkg::*;

  localparam int WPROD_W = 2 * CH_W;
  localparam int APROD_W = 2 * DIM_W;

  // Config registers
  logic [DIM_W-1:0] width_r, height_r;
  logic [DIM_W-1:0] eff_w, eff_h, w_m1, h_m1;

  // Item registers
  logic [OP_W-1:0]  op_r;
  logic [POS_W-1:0] xp_r, yp_r;
  logic [CH_W-1:0]  red_r, green_r, blue_r;
  logic [CH_W-1:0]  wts_r [4];
  logic [ADDR_W-1:0] addr_r;
  logic [CH_W-1:0]  wt_r;
  logic [PIX_W-1:0] rd_data_r;
  logic [ADDR_W-1:0] clr_cnt_r;
  logic             acc_r;
  logic [CH_W-1:0]  res_red_r, res_green_r, res_blue_r;

  logic [PIX_W-1:0] mem [FRAME_DEPTH];
  logic             mem_we;
  logic [ADDR_W-1:0] mem_addr;
  logic [PIX_W-1:0] mem_wdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= DIM_RESET;
      height_r <= DIM_RESET;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_WIDTH:  width_r  <= cfg_wdata;
        CFG_HEIGHT: height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign eff_w = (width_r < DIM_MIN) ? DIM_MIN : ((width_r > DIM_MAX_W) ? DIM_MAX_W : width_r);
  assign eff_h = (height_r < DIM_MIN) ? DIM_MIN :
                 ((height_r > DIM_MAX_H) ? DIM_MAX_H : height_r);
  assign w_m1  = eff_w - 1'b1;
  assign h_m1  = eff_h - 1'b1;

  // Range checks
  logic [INT_W-1:0] xi, yi;
  logic             splat_ok, px_ok, ok;

  assign xi       = xp_r[POS_W-1:FRAC_W];
  assign yi       = yp_r[POS_W-1:FRAC_W];
  assign splat_ok = ({1'b0, xp_r} <= {w_m1, FRAC_W'(0)}) &&
                    ({1'b0, yp_r} <= {h_m1, FRAC_W'(0)});
  assign px_ok    = (DIM_W'(xi) < eff_w) && (DIM_W'(yi) < eff_h);

  always_comb begin
    case (op_r)
      OP_SPLAT:          ok = splat_ok;
      OP_READ, OP_WRITE: ok = px_ok;
      default:           ok = 1'b0;
    endcase
  end

  // Fractions: (f*255)>>8 is f-1 for non-zero f
  logic [CH_W-1:0]    fx, fy, ix, iy;
  logic [WPROD_W-1:0] wsum [4];
  logic [CH_W-1:0]    wa [4];
  logic [CH_W-1:0]    wb [4];

  assign fx = (xp_r[FRAC_W-1:0] == '0) ? '0 : xp_r[FRAC_W-1:0] - 1'b1;
  assign fy = (yp_r[FRAC_W-1:0] == '0) ? '0 : yp_r[FRAC_W-1:0] - 1'b1;
  assign ix = ~fx;
  assign iy = ~fy;

  always_comb begin
    wa[0] = ix; wb[0] = iy;
    wa[1] = fx; wb[1] = iy;
    wa[2] = ix; wb[2] = fy;
    wa[3] = fx; wb[3] = fy;
    for (int i = 0; i < 4; i++) begin
      wsum[i] = wa[i] * wb[i] + WPROD_W'(wa[i]) + WPROD_W'(wb[i]);
    end
  end

  // Neighbour selection
  logic [DIM_W-1:0]   xn, yn;
  logic               nb_ok, nb_inner;
  logic [APROD_W-1:0] nb_prod, px_prod;
  logic [ADDR_W-1:0]  nb_addr, px_addr;

  assign xn       = DIM_W'(xi) + DIM_W'(cmd.nb_idx[0]);
  assign yn       = DIM_W'(yi) + DIM_W'(cmd.nb_idx[1]);
  assign nb_ok    = (xn < eff_w) && (yn < eff_h);
  assign nb_inner = (xn != '0) && (yn != '0) && (xn != w_m1) && (yn != h_m1);
  assign nb_prod  = yn * eff_w;
  assign nb_addr  = ADDR_W'(nb_prod + APROD_W'(xn));
  assign px_prod  = DIM_W'(yi) * eff_w;
  assign px_addr  = ADDR_W'(px_prod + APROD_W'(xi));

  // Saturating merge of the weighted colour
  function automatic logic [CH_W-1:0] blend(input logic [CH_W-1:0] pix,
                                            input logic [CH_W-1:0] col,
                                            input logic [CH_W-1:0] wt);
    logic [WPROD_W-1:0] prod;
    logic [CH_W:0]      sum;
    prod = col * wt;
    sum  = {1'b0, pix} + {1'b0, prod[WPROD_W-1:CH_W]};
    return sum[CH_W] ? '1 : sum[CH_W-1:0];
  endfunction

  logic [PIX_W-1:0] merged;
  assign merged = {blend(rd_data_r[3*CH_W-1:2*CH_W], red_r, wt_r),
                   blend(rd_data_r[2*CH_W-1:CH_W], green_r, wt_r),
                   blend(rd_data_r[CH_W-1:0], blue_r, wt_r)};

  // Memory port
  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = px_addr;
    mem_wdata = {red_r, green_r, blue_r};
    if (cmd.clear) begin
      mem_we    = 1'b1;
      mem_addr  = clr_cnt_r;
      mem_wdata = '0;
    end else if (cmd.nb_wr) begin
      mem_we    = 1'b1;
      mem_addr  = addr_r;
      mem_wdata = merged;
    end else if (cmd.nb_rd) begin
      mem_addr  = nb_addr;
    end else if (cmd.px_rd || cmd.px_wr) begin
      mem_we    = cmd.px_wr;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    rd_data_r <= mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clear) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= in_opcode;
      xp_r    <= in_x_pos;
      yp_r    <= in_y_pos;
      red_r   <= in_red;
      green_r <= in_green;
      blue_r  <= in_blue;
    end
    if (cmd.decode) begin
      for (int i = 0; i < 4; i++) wts_r[i] <= wsum[i][WPROD_W-1:CH_W];
    end
    if (cmd.nb_rd) begin
      addr_r <= nb_addr;
      wt_r   <= nb_inner ? wts_r[cmd.nb_idx] : BORDER_WEIGHT;
    end
    if (cmd.result) begin
      acc_r <= ok;
      if (ok && (op_r == OP_READ)) begin
        res_red_r   <= rd_data_r[3*CH_W-1:2*CH_W];
        res_green_r <= rd_data_r[2*CH_W-1:CH_W];
        res_blue_r  <= rd_data_r[CH_W-1:0];
      end else begin
        res_red_r   <= '0;
        res_green_r <= '0;
        res_blue_r  <= '0;
      end
    end
  end

  assign stat.clr_last = (clr_cnt_r == ADDR_W'(FRAME_DEPTH - 1));
  assign stat.ok       = ok;
  assign stat.nb_ok    = nb_ok;
  assign stat.op       = op_r;

  assign res_accepted = acc_r;
  assign res_red      = res_red_r;
  assign res_green    = res_green_r;
  assign res_blue     = res_blue_r;

endmodule

// ----- rtl/core/sspf_checker.sv -----
module sspf_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic                             out_accepted,
  input logic [sspf_pkg::CH_W-1:0]        out_red,
  input logic [sspf_pkg::CH_W-1:0]        out_green,
  input logic [sspf_pkg::CH_W-1:0]        out_blue
);

  // Clearing pass follows reset: no item taken straight after it
  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("item input ready straight after reset");

  // One item in flight: an accepted item closes the input next cycle
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input ready again right after an accept");

  // A rejected item reads back black
  a_reject_black: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_accepted) |->
      (out_red == '0) && (out_green == '0) && (out_blue == '0))
    else $error("rejected item carries colour");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      out_valid && $stable(out_accepted) && $stable(out_red) &&
      $stable(out_green) && $stable(out_blue))
    else $error("result changed while stalled");

endmodule

bind subpixel_splat_framebuffer_top sspf_checker u_sspf_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_accepted (out_accepted),
  .out_red      (out_red),
  .out_green    (out_green),
  .out_blue     (out_blue)
);

// ----- sim/tb.sv -----
`timescale 1ns / 1ps

// Self-checking bench for the sub-pixel splat framebuffer.
// Every input item is run through a cycle-free copy of the framebuffer kept here;
// the copy's answer is queued and compared with the next result item that the
// block hands over. The run covers a directed set of corner items, random
// traffic at the reset size, a sweep of matrix sizes (clamped extremes included)
// and writes to register indexes that the block ignores.
module tb;
  import sspf_pkg::*;

  // Opcode and register indexes that the package leaves unnamed
  localparam logic [OP_W-1:0]      OP_SPARE    = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED3 = 2'd3;

  // Cycles with no handshake on any channel before the run is abandoned.
  // Covers the clearing pass after reset several times over.
  localparam int QUIET_LIMIT = 20000;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [POS_W-1:0] x;
    logic [POS_W-1:0] y;
    logic [CH_W-1:0]  r;
    logic [CH_W-1:0]  g;
    logic [CH_W-1:0]  b;
  } pix_req_t;

  typedef struct packed {
    logic            acc;
    logic [CH_W-1:0] r;
    logic [CH_W-1:0] g;
    logic [CH_W-1:0] b;
  } pix_ans_t;

  // Receiver behaviour, picked anew at random whenever the current mode runs out
  typedef enum logic [1:0] {RX_OPEN, RX_CADENCE, RX_RANDOM, RX_BURSTY} rx_mode_t;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  logic [OP_W-1:0]      in_opcode = '0;
  logic [POS_W-1:0]     in_x_pos  = '0;
  logic [POS_W-1:0]     in_y_pos  = '0;
  logic [CH_W-1:0]      in_red    = '0;
  logic [CH_W-1:0]      in_green  = '0;
  logic [CH_W-1:0]      in_blue   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 out_accepted;
  logic [CH_W-1:0]      out_red;
  logic [CH_W-1:0]      out_green;
  logic [CH_W-1:0]      out_blue;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DIM_W-1:0]     cfg_data  = '0;

  subpixel_splat_framebuffer_top dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_opcode    (in_opcode),
    .in_x_pos     (in_x_pos),
    .in_y_pos     (in_y_pos),
    .in_red       (in_red),
    .in_green     (in_green),
    .in_blue      (in_blue),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_accepted (out_accepted),
    .out_red      (out_red),
    .out_green    (out_green),
    .out_blue     (out_blue),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Framebuffer copy: raw register values, pixels as {r,g,b}
  // ---------------------------------------------------------------------------
  logic [DIM_W-1:0] width_reg  = DIM_RESET;
  logic [DIM_W-1:0] height_reg = DIM_RESET;
  logic [PIX_W-1:0] frame_model [FRAME_DEPTH];

  pix_ans_t    pixel_answers [$];   // answers still owed by the block, oldest first
  int unsigned mismatches   = 0;
  int unsigned burst_left   = 0;
  int unsigned quiet_cycles = 0;
  int unsigned last_col     = 0;    // integer position of the latest splat, so that
  int unsigned last_row     = 0;    // reads can land on the pixels it touched

  // Dimensions are clamped to 2..MAX at use, not at write
  function automatic int unsigned clamp_dim(logic [DIM_W-1:0] v, int unsigned hi);
    if (v < DIM_MIN) return DIM_MIN;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int unsigned cols_now();
    return clamp_dim(width_reg, MAX_WIDTH);
  endfunction

  function automatic int unsigned rows_now();
    return clamp_dim(height_reg, MAX_HEIGHT);
  endfunction

  function automatic int unsigned corner_share(int unsigned a, int unsigned b);
    return ((a * b + a + b) >> 8) & 8'hFF;
  endfunction

  function automatic logic [CH_W-1:0] sat_add(logic [CH_W-1:0] a, int unsigned b);
    int unsigned s;
    s = a + b;
    return (s > 255) ? 8'hFF : 8'(s);
  endfunction

  function automatic logic [PIX_W-1:0] blend_pixel(logic [PIX_W-1:0] p, pix_req_t q,
                                                   int unsigned wt);
    return {sat_add(p[23:16], (q.r * wt) >> 8),
            sat_add(p[15:8],  (q.g * wt) >> 8),
            sat_add(p[7:0],   (q.b * wt) >> 8)};
  endfunction

  // Applies one item to the copy and returns the result item it should produce
  function automatic pix_ans_t framebuffer_step(pix_req_t q);
    pix_ans_t    a;
    int unsigned w, h, xi, yi, fx, fy, xn, yn, idx, wt, i;
    int unsigned wts [4];
    a  = '0;
    w  = cols_now();
    h  = rows_now();
    xi = q.x >> FRAC_W;
    yi = q.y >> FRAC_W;
    if (q.op == OP_SPLAT) begin
      if (q.x > ((w - 1) << FRAC_W) || q.y > ((h - 1) << FRAC_W)) return a;
      fx = (q.x[FRAC_W-1:0] * 255) >> 8;
      fy = (q.y[FRAC_W-1:0] * 255) >> 8;
      wts[0] = corner_share(255 - fx, 255 - fy);
      wts[1] = corner_share(fx, 255 - fy);
      wts[2] = corner_share(255 - fx, fy);
      wts[3] = corner_share(fx, fy);
      for (i = 0; i < 4; i++) begin
        xn = xi + (i & 1);
        yn = yi + (i >> 1);
        if (xn < w && yn < h) begin
          // border pixels take the flat weight
          wt  = (xn > 0 && yn > 0 && xn < w - 1 && yn < h - 1) ? wts[i] : BORDER_WEIGHT;
          idx = yn * w + xn;
          frame_model[idx] = blend_pixel(frame_model[idx], q, wt);
        end
      end
      a.acc = 1'b1;
    end else if (q.op == OP_READ || q.op == OP_WRITE) begin
      if (xi >= w || yi >= h) return a;
      idx = (yi * w + xi) % FRAME_DEPTH;
      if (q.op == OP_READ) {a.r, a.g, a.b} = frame_model[idx];
      else frame_model[idx] = {q.r, q.g, q.b};
      a.acc = 1'b1;
    end
    return a;
  endfunction

  // ---------------------------------------------------------------------------
  // Item construction
  // ---------------------------------------------------------------------------
  function automatic logic [POS_W-1:0] fixpos(int unsigned whole, int unsigned frac);
    return POS_W'((whole << FRAC_W) | (frac & 8'hFF));
  endfunction

  function automatic pix_req_t mk_req(logic [OP_W-1:0] op, logic [POS_W-1:0] x,
                                      logic [POS_W-1:0] y, logic [CH_W-1:0] r,
                                      logic [CH_W-1:0] g, logic [CH_W-1:0] b);
    return '{op: op, x: x, y: y, r: r, g: g, b: b};
  endfunction

  // Channel levels lean towards the extremes to exercise saturation
  function automatic logic [CH_W-1:0] random_level();
    case ($urandom_range(0, 5))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return CH_W'($urandom_range(0, 255));
    endcase
  endfunction

  // Mostly legal splats, reads (often near them) and legal writes, some edge hits, some noise
  function automatic pix_req_t random_request();
    pix_req_t    q;
    int unsigned w, h, pick;
    w    = cols_now();
    h    = rows_now();
    q.r  = random_level();
    q.g  = random_level();
    q.b  = random_level();
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      q.op = OP_SPLAT;
      q.x  = POS_W'($urandom_range(0, (w - 1) << FRAC_W));
      q.y  = POS_W'($urandom_range(0, (h - 1) << FRAC_W));
      last_col = q.x >> FRAC_W;
      last_row = q.y >> FRAC_W;
    end else if (pick < 48) begin
      // on or just past the last column / row
      q.op = OP_SPLAT;
      q.x  = $urandom_range(0, 1) ? fixpos(w - 1, $urandom_range(0, 3))
                                  : POS_W'($urandom_range(0, (w - 1) << FRAC_W));
      q.y  = $urandom_range(0, 1) ? fixpos(h - 1, $urandom_range(0, 3))
                                  : POS_W'($urandom_range(0, (h - 1) << FRAC_W));
    end else if (pick < 70) begin
      q.op = OP_READ;
      if ($urandom_range(0, 1)) begin
        q.x = fixpos(last_col + $urandom_range(0, 1), $urandom_range(0, 255));
        q.y = fixpos(last_row + $urandom_range(0, 1), $urandom_range(0, 255));
      end else begin
        q.x = fixpos($urandom_range(0, w - 1), $urandom_range(0, 255));
        q.y = fixpos($urandom_range(0, h - 1), $urandom_range(0, 255));
      end
    end else if (pick < 85) begin
      q.op = OP_WRITE;
      q.x  = fixpos($urandom_range(0, w - 1), $urandom_range(0, 255));
      q.y  = fixpos($urandom_range(0, h - 1), $urandom_range(0, 255));
    end else if (pick < 95) begin
      q.op = OP_W'($urandom_range(0, 2));
      q.x  = POS_W'($urandom_range(0, 16383));
      q.y  = POS_W'($urandom_range(0, 16383));
    end else begin
      q.op = OP_SPARE;
      q.x  = POS_W'($urandom_range(0, 16383));
      q.y  = POS_W'($urandom_range(0, 16383));
    end
    return q;
  endfunction

  // ---------------------------------------------------------------------------
  // Channel drivers
  // ---------------------------------------------------------------------------

  // Sends one item: bursts of random length, random gaps between them.
  // in_valid stays high across a burst; the payload moves on at the falling edge
  // after the previous item was taken.
  task automatic send_item(input pix_req_t q);
    int unsigned gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
    end
    burst_left--;
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  = 1'b1;
    in_opcode = q.op;
    in_x_pos  = q.x;
    in_y_pos  = q.y;
    in_red    = q.r;
    in_green  = q.g;
    in_blue   = q.b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pixel_answers.push_back(framebuffer_step(q));
  endtask

  // Sender goes quiet until every owed result item has come back
  task automatic wait_for_answers();
    @(negedge clk);
    in_valid   = 1'b0;
    burst_left = 0;
    while (pixel_answers.size() > 0) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [DIM_W-1:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_WIDTH) width_reg = val;
    else if (idx == CFG_HEIGHT) height_reg = val;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic random_items(input int unsigned n);
    repeat (n) send_item(random_request());
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: stalls on its own schedule, independent of the sender
  // ---------------------------------------------------------------------------
  rx_mode_t    rx_mode = RX_OPEN;
  int unsigned rx_left = 0;
  int unsigned rx_hold = 0;

  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_left = $urandom_range(20, 120);
    end
    rx_left--;
    case (rx_mode)
      RX_OPEN:    out_ready = 1'b1;
      RX_CADENCE: out_ready = (rx_left % 3) != 0;
      RX_RANDOM:  out_ready = $urandom_range(0, 99) < 60;
      default: begin
        if (rx_hold == 0 && $urandom_range(0, 7) == 0) rx_hold = $urandom_range(1, 12);
        if (rx_hold > 0) begin
          out_ready = 1'b0;
          rx_hold--;
        end else begin
          out_ready = 1'b1;
        end
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Result check: every item taken is matched against the oldest owed answer
  // ---------------------------------------------------------------------------
  task automatic log_mismatch(input string what, input pix_ans_t want, input pix_ans_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t %s: want acc=%0d rgb=%02h_%02h_%02h got acc=%0d rgb=%02h_%02h_%02h",
               $time, what, want.acc, want.r, want.g, want.b,
               got.acc, got.r, got.g, got.b);
  endtask

  always @(posedge clk) begin
    pix_ans_t got, want;
    if (rst_n && out_valid && out_ready) begin
      got = '{acc: out_accepted, r: out_red, g: out_green, b: out_blue};
      if (pixel_answers.size() == 0) begin
        log_mismatch("result item with nothing owed", '0, got);
      end else begin
        want = pixel_answers.pop_front();
        if (got.acc !== want.acc || got.r !== want.r ||
            got.g !== want.g || got.b !== want.b)
          log_mismatch("result item differs", want, got);
      end
    end
  end

  // Watchdog: abandons the run after a long stretch with no handshake anywhere
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("subpixel_splat_framebuffer_top: mismatch");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Corner items at the reset size of 16 x 16
  task automatic test_directed();
    send_item(mk_req(OP_READ,  fixpos(0, 0), fixpos(0, 0), 8'h00, 8'h00, 8'h00));
    send_item(mk_req(OP_WRITE, fixpos(0, 0), fixpos(0, 0), 8'hFF, 8'hFF, 8'hFF));
    send_item(mk_req(OP_READ,  fixpos(0, 0), fixpos(0, 0), 8'h00, 8'h00, 8'h00));
    // fraction bits are ignored by read and write
    send_item(mk_req(OP_WRITE, fixpos(15, 8'hFF), fixpos(15, 8'hFF), 8'h12, 8'h34, 8'h56));
    send_item(mk_req(OP_READ,  fixpos(15, 8'h7F), fixpos(15, 8'h01), 8'hFF, 8'hFF, 8'hFF));
    // whole-pixel splat: all weight on the first neighbour
    send_item(mk_req(OP_SPLAT, fixpos(5, 0), fixpos(5, 0), 8'hFF, 8'h80, 8'h01));
    // full fractions: weight mostly on the diagonal neighbour
    send_item(mk_req(OP_SPLAT, fixpos(7, 8'hFF), fixpos(7, 8'hFF), 8'hFF, 8'hFF, 8'hFF));
    // last column: right-hand neighbours fall outside and are skipped
    send_item(mk_req(OP_SPLAT, fixpos(15, 0), fixpos(3, 8'h80), 8'hC0, 8'h60, 8'h30));
    // just past the last column / row: rejected
    send_item(mk_req(OP_SPLAT, fixpos(15, 1), fixpos(3, 0), 8'hFF, 8'hFF, 8'hFF));
    send_item(mk_req(OP_SPLAT, fixpos(2, 0), fixpos(15, 8'h10), 8'hFF, 8'hFF, 8'hFF));
    // top-left corner: border weight on all but the diagonal neighbour
    send_item(mk_req(OP_SPLAT, fixpos(0, 8'h40), fixpos(0, 8'hC0), 8'h90, 8'hA0, 8'hB0));
    // saturating add on a nearly full pixel
    send_item(mk_req(OP_WRITE, fixpos(9, 0), fixpos(9, 0), 8'hFA, 8'hFA, 8'hFA));
    send_item(mk_req(OP_SPLAT, fixpos(9, 0), fixpos(9, 0), 8'hFF, 8'hFF, 8'hFF));
    send_item(mk_req(OP_READ,  fixpos(9, 0), fixpos(9, 0), 8'h00, 8'h00, 8'h00));
    send_item(mk_req(OP_READ,  fixpos(5, 0), fixpos(5, 0), 8'h00, 8'h00, 8'h00));
    send_item(mk_req(OP_READ,  fixpos(8, 0), fixpos(8, 0), 8'h00, 8'h00, 8'h00));
    send_item(mk_req(OP_READ,  fixpos(15, 0), fixpos(3, 0), 8'h00, 8'h00, 8'h00));
    send_item(mk_req(OP_READ,  fixpos(15, 0), fixpos(4, 0), 8'h00, 8'h00, 8'h00));
    send_item(mk_req(OP_READ,  fixpos(0, 0), fixpos(0, 0), 8'h00, 8'h00, 8'h00));
    // read and write outside the matrix
    send_item(mk_req(OP_READ,  fixpos(16, 0), fixpos(0, 0), 8'h00, 8'h00, 8'h00));
    send_item(mk_req(OP_READ,  fixpos(0, 0), 14'h3FFF, 8'h00, 8'h00, 8'h00));
    send_item(mk_req(OP_WRITE, 14'h3FFF, fixpos(1, 0), 8'hFF, 8'hFF, 8'hFF));
    // unused opcode: no effect, all-zero answer
    send_item(mk_req(OP_SPARE, 14'h3FFF, 14'h3FFF, 8'hFF, 8'hFF, 8'hFF));
    // bottom-right corner exactly: only the pixel itself is in range
    send_item(mk_req(OP_SPLAT, fixpos(15, 0), fixpos(15, 0), 8'h40, 8'h40, 8'h40));
    send_item(mk_req(OP_READ,  fixpos(15, 0), fixpos(15, 0), 8'h00, 8'h00, 8'h00));
  endtask

  task automatic test_reset_size_random();
    random_items(100);
  endtask

  // Matrix sizes across the clamp range; each phase starts with the block idle.
  // Halfway through each phase the sender holds off until all answers are in.
  task automatic test_dimension_sweep();
    logic [DIM_W-1:0] cols [9] = '{7'd0, 7'd64, 7'd127, 7'd2,  7'd64, 7'd1, 7'd3, 7'd33, 7'd0};
    logic [DIM_W-1:0] rows [9] = '{7'd1, 7'd64, 7'd65,  7'd64, 7'd2,  7'd127, 7'd5, 7'd0, 7'd0};
    int unsigned k;
    for (k = 0; k < 9; k++) begin
      wait_for_answers();
      if (k == 8) begin
        cols[k] = DIM_W'($urandom_range(0, 127));
        rows[k] = DIM_W'($urandom_range(0, 127));
      end
      write_register(CFG_WIDTH, cols[k]);
      write_register(CFG_HEIGHT, rows[k]);
      random_items(40);
      wait_for_answers();
      random_items(40);
    end
  endtask

  // Indexes past the register list must leave the size alone
  task automatic test_unused_registers();
    wait_for_answers();
    write_register(CFG_WIDTH, 7'd12);
    write_register(CFG_HEIGHT, 7'd9);
    write_register(CFG_UNUSED2, 7'h7F);
    write_register(CFG_UNUSED3, DIM_W'($urandom_range(0, 127)));
    random_items(30);
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    for (int i = 0; i < FRAME_DEPTH; i++) frame_model[i] = '0;
    rst_n = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // first item waits out the clearing pass on in_ready
    test_directed();
    test_reset_size_random();
    test_dimension_sweep();
    test_unused_registers();

    wait_for_answers();
    repeat (16) @(posedge clk);
    if (mismatches == 0 && pixel_answers.size() == 0) begin
      $display("subpixel_splat_framebuffer_top: match");
    end else begin
      $display("subpixel_splat_framebuffer_top: mismatch");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/sspf_pkg.sv
rtl/core/sspf_ctrl.sv
rtl/core/sspf_datapath.sv
rtl/core/subpixel_splat_framebuffer_top.sv
rtl/core/sspf_checker.sv
sim/tb.sv
